// ===== rtl/crm_pkg.sv =====
package crm_pkg;

    localparam int DATA_W       = 16;
    localparam int FRAC_BITS    = 8;
    localparam int PROD_W       = 2 * DATA_W;
    // 63 channels x 9 taps of full-scale products plus the bias stay below 2^40
    localparam int ACC_W        = 41;
    localparam int FMAP_DEPTH   = 32768;
    localparam int FMAP_AW      = 15;
    localparam int WEIGHT_DEPTH = 32768;
    localparam int WEIGHT_AW    = 15;
    localparam int BIAS_DEPTH   = 64;
    localparam int BIAS_AW      = 6;
    localparam int FADDR_W      = 23;
    localparam int WADDR_W      = 16;
    localparam int OUT_W        = 15;
    localparam logic [OUT_W-1:0] OUT_MAX = 15'h7fff;

    localparam logic [1:0] ACT_PIXEL   = 2'd0;
    localparam logic [1:0] ACT_WEIGHT  = 2'd1;
    localparam logic [1:0] ACT_BIAS    = 2'd2;
    localparam logic [1:0] ACT_COMPUTE = 2'd3;

    localparam logic [1:0] REG_MAP_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IN_CHANNELS = 2'd1;
    localparam logic [1:0] REG_OUT_CHANNELS = 2'd2;
    localparam logic [1:0] REG_PIXEL_MAJOR = 2'd3;

    typedef struct packed {
        logic       accept;
        logic       check;
        logic       pos_init;
        logic       mac_step;
        logic       bias_add;
        logic       out_load;
        logic [1:0] pos;
    } crm_cmd_t;

    typedef struct packed {
        logic bad;
        logic icc_zero;
        logic tap_last;
        logic pipe_busy;
    } crm_status_t;

endpackage

// ===== rtl/crm_ram.sv =====
module crm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/crm_ctrl.sv =====
module crm_ctrl
    import crm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  in_action,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  crm_status_t status,
    output crm_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_POS,
        ST_MAC,
        ST_DRAIN,
        ST_BIAS,
        ST_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       load_out;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign load_out  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.pos      = pos_reg;
        cmd.out_load = load_out;
        state_next   = state_reg;
        pos_next     = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                pos_next = 2'd0;
                if (accept && in_action == ACT_COMPUTE)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.bad ? ST_FINISH : ST_POS;
            end
            ST_POS:
            begin
                cmd.pos_init = 1'b1;
                state_next   = status.icc_zero ? ST_BIAS : ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (status.tap_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_BIAS;
                end
            end
            ST_BIAS:
            begin
                cmd.bias_add = 1'b1;
                pos_next     = pos_reg + 2'd1;
                state_next   = (pos_reg == 2'd3) ? ST_FINISH : ST_POS;
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/crm_datapath.sv =====
module crm_datapath
    import crm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  crm_cmd_t           cmd,
    input  logic [1:0]         action,
    input  logic [14:0]        addr,
    input  logic signed [15:0] value,
    input  logic [5:0]         filter_sel,
    input  logic [5:0]         pool_row,
    input  logic [5:0]         pool_col,
    input  logic [7:0]         map_width,
    input  logic [5:0]         in_channel_count,
    input  logic [6:0]         out_channel_count,
    input  logic               pixel_major,
    output crm_status_t        status,
    output logic [OUT_W-1:0]   pooled_value,
    output logic [OUT_W-1:0]   out_index,
    output logic               bad_request
);

    logic [5:0]                f_reg, pr_reg, pc_reg;
    logic                      bad_reg;
    logic [13:0]               pix_reg;
    logic [12:0]               fp_reg;
    logic [15:0]               mw2_reg;
    logic [11:0]               fic_reg;
    logic [14:0]               r0mw_reg;
    logic [6:0]                col0_reg;
    logic [FADDR_W-1:0]        chbase_reg, rowbase_reg;
    logic [1:0]                kj_reg, ki_reg;
    logic [5:0]                ch_reg;
    logic [WADDR_W-1:0]        waddr_reg;
    logic                      iss_v_reg, prod_v_reg, oor_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, best_reg;
    logic [OUT_W-1:0]          value_reg, index_reg;
    logic                      bad_out_reg;

    logic [7:0]                conv;
    logic [6:0]                pool;
    logic                      bad;
    logic [FADDR_W-1:0]        faddr;
    logic [WADDR_W-1:0]        wstart;
    logic [6:0]                r0;
    logic [DATA_W-1:0]         fdata, wdata, bdata;
    logic signed [ACC_W-1:0]   bias_term, sum;
    logic [ACC_W-FRAC_BITS-1:0] q;
    logic [OUT_W-1:0]          sat_value;
    logic [19:0]               idx_cm;
    logic [20:0]               idx_pm;

    assign conv   = (map_width >= 8'd2) ? map_width - 8'd2 : 8'd0;
    assign pool   = conv[7:1];
    assign bad    = ({1'b0, f_reg} >= out_channel_count)
                    || ({1'b0, pr_reg} >= pool) || ({1'b0, pc_reg} >= pool);
    assign faddr  = rowbase_reg + FADDR_W'(col0_reg) + FADDR_W'(kj_reg);
    assign wstart = {1'b0, fic_reg, 3'b000} + WADDR_W'(fic_reg);
    assign r0     = {pr_reg, 1'b0} + 7'(cmd.pos[1]);

    crm_ram #(.WIDTH(DATA_W), .DEPTH(FMAP_DEPTH)) u_feature_ram (
        .clk     (clk),
        .wr_en   (cmd.accept && action == ACT_PIXEL),
        .wr_addr (addr[FMAP_AW-1:0]),
        .wr_data (value),
        .rd_addr (faddr[FMAP_AW-1:0]),
        .rd_data (fdata)
    );

    crm_ram #(.WIDTH(DATA_W), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
        .clk     (clk),
        .wr_en   (cmd.accept && action == ACT_WEIGHT),
        .wr_addr (addr[WEIGHT_AW-1:0]),
        .wr_data (value),
        .rd_addr (waddr_reg[WEIGHT_AW-1:0]),
        .rd_data (wdata)
    );

    // drop bias writes beyond the store
    crm_ram #(.WIDTH(DATA_W), .DEPTH(BIAS_DEPTH)) u_bias_ram (
        .clk     (clk),
        .wr_en   (cmd.accept && action == ACT_BIAS && addr[14:BIAS_AW] == '0),
        .wr_addr (addr[BIAS_AW-1:0]),
        .wr_data (value),
        .rd_addr (f_reg[BIAS_AW-1:0]),
        .rd_data (bdata)
    );

    assign bias_term = {{(ACC_W-DATA_W-FRAC_BITS){bdata[DATA_W-1]}}, bdata, {FRAC_BITS{1'b0}}};
    assign sum       = acc_reg + bias_term;
    assign q         = best_reg[ACC_W-1:FRAC_BITS];
    assign sat_value = (q > (ACC_W-FRAC_BITS)'(OUT_MAX)) ? OUT_MAX : q[OUT_W-1:0];
    assign idx_cm    = 20'(fp_reg) * 20'(pool) + 20'(pix_reg);
    assign idx_pm    = 21'(pix_reg) * 21'(out_channel_count) + 21'(f_reg);

    assign status.bad       = bad;
    assign status.icc_zero  = (in_channel_count == 6'd0);
    assign status.tap_last  = (kj_reg == 2'd2) && (ki_reg == 2'd2)
                              && (ch_reg == in_channel_count - 6'd1);
    assign status.pipe_busy = iss_v_reg || prod_v_reg;

    assign pooled_value = value_reg;
    assign out_index    = index_reg;
    assign bad_request  = bad_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            iss_v_reg  <= cmd.mac_step;
            prod_v_reg <= iss_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            f_reg  <= filter_sel;
            pr_reg <= pool_row;
            pc_reg <= pool_col;
        end
        if (cmd.check)
        begin
            bad_reg  <= bad;
            pix_reg  <= 14'(pr_reg) * 14'(pool) + 14'(pc_reg);
            fp_reg   <= 13'(f_reg) * 13'(pool);
            mw2_reg  <= 16'(map_width) * 16'(map_width);
            fic_reg  <= 12'(f_reg) * 12'(in_channel_count);
            best_reg <= '0;
        end
        if (cmd.pos_init)
        begin
            r0mw_reg    <= 15'(r0) * 15'(map_width);
            rowbase_reg <= FADDR_W'(15'(r0) * 15'(map_width));
            chbase_reg  <= '0;
            col0_reg    <= {pc_reg, 1'b0} + 7'(cmd.pos[0]);
            kj_reg      <= 2'd0;
            ki_reg      <= 2'd0;
            ch_reg      <= 6'd0;
            waddr_reg   <= wstart;
            acc_reg     <= '0;
        end
        if (cmd.mac_step)
        begin
            // operands beyond either store read as zero
            oor_reg   <= (faddr[FADDR_W-1:FMAP_AW] != '0) || waddr_reg[WADDR_W-1];
            waddr_reg <= waddr_reg + WADDR_W'(1);
            if (kj_reg == 2'd2)
            begin
                kj_reg <= 2'd0;
                if (ki_reg == 2'd2)
                begin
                    ki_reg      <= 2'd0;
                    ch_reg      <= ch_reg + 6'd1;
                    chbase_reg  <= chbase_reg + FADDR_W'(mw2_reg);
                    rowbase_reg <= chbase_reg + FADDR_W'(mw2_reg) + FADDR_W'(r0mw_reg);
                end
                else
                begin
                    ki_reg      <= ki_reg + 2'd1;
                    rowbase_reg <= rowbase_reg + FADDR_W'(map_width);
                end
            end
            else
            begin
                kj_reg <= kj_reg + 2'd1;
            end
        end
        if (iss_v_reg)
        begin
            if (oor_reg)
            begin
                prod_reg <= '0;
            end
            else
            begin
                prod_reg <= PROD_W'($signed(fdata)) * PROD_W'($signed(wdata));
            end
        end
        if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        // zero floor of best doubles as the ReLU
        if (cmd.bias_add && sum > best_reg)
        begin
            best_reg <= sum;
        end
        if (cmd.out_load)
        begin
            bad_out_reg <= bad_reg;
            value_reg   <= bad_reg ? '0 : sat_value;
            index_reg   <= bad_reg ? '0 : (pixel_major ? idx_pm[OUT_W-1:0] : idx_cm[OUT_W-1:0]);
        end
    end

endmodule

// ===== rtl/conv3x3_relu_maxpool_layer.sv =====
// Channel   Direction  Transaction
// s_axis    in         tuser action; tdata addr, value, filter_sel, pool_row, pool_col
// m_axis    out        tuser bad_request; tdata pooled_value, out_index
// apb       in         map_width, in_channel_count, out_channel_count, pixel_major
//
// A load writes its store at the accept edge.
// A compute walks nine taps per input channel for each of four conv positions
// through the single multiply-accumulate; an out-of-range request skips the walk
// and goes from the check straight to the result.
// Reset clears control, config and valid bits, not data registers or the stores.
// A stalled result waits in the output register; loads are still taken then.
module conv3x3_relu_maxpool_layer
    import crm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // addr[14:0], value[30:15], filter_sel[36:31],
                                       // pool_row[42:37], pool_col[48:43], zero
    input  logic [1:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // pooled_value[14:0], out_index[29:15], zero
    output logic        m_axis_tuser,  // bad_request
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    crm_cmd_t         cmd;
    crm_status_t      status;
    logic [7:0]       map_width_reg;
    logic [5:0]       in_channels_reg;
    logic [6:0]       out_channels_reg;
    logic             pixel_major_reg;
    logic [OUT_W-1:0] pooled_value, out_index;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg    <= 8'd128;
            in_channels_reg  <= 6'd1;
            out_channels_reg <= 7'd8;
            pixel_major_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MAP_WIDTH:    map_width_reg    <= pwdata[7:0];
                REG_IN_CHANNELS:  in_channels_reg  <= pwdata[5:0];
                REG_OUT_CHANNELS: out_channels_reg <= pwdata[6:0];
                REG_PIXEL_MAJOR:  pixel_major_reg  <= pwdata[0];
                default:          map_width_reg    <= map_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MAP_WIDTH:    prdata = {24'd0, map_width_reg};
            REG_IN_CHANNELS:  prdata = {26'd0, in_channels_reg};
            REG_OUT_CHANNELS: prdata = {25'd0, out_channels_reg};
            REG_PIXEL_MAJOR:  prdata = {31'd0, pixel_major_reg};
            default:          prdata = 32'd0;
        endcase
    end

    crm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    crm_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .action            (s_axis_tuser),
        .addr              (s_axis_tdata[14:0]),
        .value             (s_axis_tdata[30:15]),
        .filter_sel        (s_axis_tdata[36:31]),
        .pool_row          (s_axis_tdata[42:37]),
        .pool_col          (s_axis_tdata[48:43]),
        .map_width         (map_width_reg),
        .in_channel_count  (in_channels_reg),
        .out_channel_count (out_channels_reg),
        .pixel_major       (pixel_major_reg),
        .status            (status),
        .pooled_value      (pooled_value),
        .out_index         (out_index),
        .bad_request       (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, out_index, pooled_value};

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("flagged result carries nonzero data");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_COMPUTE |=> !s_axis_tready)
        else $error("input taken during a compute");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != ACT_COMPUTE |=> s_axis_tready)
        else $error("load did not finish in one cycle");

endmodule

// ===== dv/tb_conv3x3_relu_maxpool_layer.sv =====
`timescale 1ns / 100ps

module tb_conv3x3_relu_maxpool_layer;
    import crm_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int RANDOM_ITEMS = 1540;

    typedef struct {
        logic [1:0]  act;
        logic [14:0] addr;
        logic [15:0] value;
        logic [5:0]  filt;
        logic [5:0]  prow;
        logic [5:0]  pcol;
    } layer_req_t;

    typedef struct {
        logic [14:0] pooled;
        logic [14:0] index;
        logic        bad;
    } pool_out_t;

    typedef struct {
        layer_req_t req;
        logic       typed;
        pool_out_t  want;
    } vector_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // addr, value, filter_sel, pool_row, pool_col, zero
    logic [1:0]  s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // pooled_value, out_index, zero
    logic        m_axis_tuser;   // bad_request
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    conv3x3_relu_maxpool_layer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // shadow of the layer state
    logic signed [15:0] feat_mem [FMAP_DEPTH];
    logic signed [15:0] wt_mem [WEIGHT_DEPTH];
    logic signed [15:0] bias_mem [BIAS_DEPTH];
    bit                 feat_set [FMAP_DEPTH];
    bit                 wt_set [WEIGHT_DEPTH];
    bit                 bias_set [BIAS_DEPTH];
    int unsigned        cfg_width;
    int unsigned        cfg_in_ch;
    int unsigned        cfg_out_ch;
    bit                 cfg_pix_major;

    pool_out_t   pending_pools [$];
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned sent_count;
    int unsigned result_count;
    int unsigned bad_count;
    int unsigned saturated_count;
    int unsigned burst_left;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned pool_size();
        return (cfg_width >= 2) ? (cfg_width - 2) / 2 : 0;
    endfunction

    function automatic bit is_bad(layer_req_t r);
        return r.filt >= cfg_out_ch || r.filt >= BIAS_DEPTH
               || r.prow >= pool_size() || r.pcol >= pool_size();
    endfunction

    function automatic longint feat_index(int unsigned ch, int unsigned row, int unsigned col);
        return longint'(ch) * cfg_width * cfg_width + longint'(row) * cfg_width + col;
    endfunction

    function automatic longint wt_index(int unsigned filt, int unsigned ch, int unsigned tap);
        return (longint'(filt) * cfg_in_ch + ch) * 9 + tap;
    endfunction

    function automatic pool_out_t predict_pool(layer_req_t r);
        pool_out_t   res;
        longint      best;
        longint      acc;
        longint      fi;
        longint      wi;
        longint      fv;
        longint      wv;
        longint      cell_idx;
        int unsigned p;
        res = '{pooled: '0, index: '0, bad: 1'b1};
        if (is_bad(r))
            return res;
        p = pool_size();
        best = 0;
        for (int a = 0; a < 2; a++)
            for (int b = 0; b < 2; b++)
            begin
                acc = 0;
                for (int unsigned ch = 0; ch < cfg_in_ch; ch++)
                    for (int k = 0; k < 9; k++)
                    begin
                        fi = feat_index(ch, 2 * r.prow + a + k / 3, 2 * r.pcol + b + k % 3);
                        wi = wt_index(r.filt, ch, k);
                        fv = (fi < FMAP_DEPTH) ? longint'(feat_mem[fi]) : 0;
                        wv = (wi < WEIGHT_DEPTH) ? longint'(wt_mem[wi]) : 0;
                        acc += fv * wv;
                    end
                acc += longint'(bias_mem[r.filt]) <<< FRAC_BITS;
                if (acc > best)
                    best = acc;
            end
        best = best >>> FRAC_BITS;
        if (best > 32767)
            best = 32767;
        cell_idx = longint'(r.prow) * p + r.pcol;
        cell_idx = cfg_pix_major ? cell_idx * cfg_out_ch + r.filt
                                 : longint'(r.filt) * p * p + cell_idx;
        res.pooled = best[14:0];
        res.index = cell_idx[14:0];
        res.bad = 1'b0;
        return res;
    endfunction

    // mirror an accepted transaction into the shadow state
    task automatic record_accept(layer_req_t r, bit typed, pool_out_t want);
        pool_out_t p;
        case (r.act)
            ACT_PIXEL:
            begin
                feat_mem[r.addr] = r.value;
                feat_set[r.addr] = 1'b1;
            end
            ACT_WEIGHT:
            begin
                wt_mem[r.addr] = r.value;
                wt_set[r.addr] = 1'b1;
            end
            ACT_BIAS:
            begin
                if (r.addr < BIAS_DEPTH)
                begin
                    bias_mem[r.addr] = r.value;
                    bias_set[r.addr] = 1'b1;
                end
            end
            default:
            begin
                p = typed ? want : predict_pool(r);
                pending_pools.push_back(p);
            end
        endcase
        sent_count++;
    endtask

    task automatic send_req(layer_req_t r, bit typed = 1'b0, pool_out_t want = '{0, 0, 0});
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.act;
        s_axis_tdata <= {7'd0, r.pcol, r.prow, r.filt, r.value, r.addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        record_accept(r, typed, want);
    endtask

    function automatic logic [15:0] random_word();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_load(logic [1:0] act, longint addr);
        layer_req_t r;
        r.act = act;
        r.addr = addr[14:0];
        r.value = random_word();
        r.filt = 6'($urandom);
        r.prow = 6'($urandom);
        r.pcol = 6'($urandom);
        send_req(r);
    endtask

    // write every store entry that a compute will read and that holds no data yet
    task automatic fill_operands(layer_req_t r);
        longint idx;
        if (is_bad(r))
            return;
        if (!bias_set[r.filt])
            send_load(ACT_BIAS, longint'(r.filt));
        for (int unsigned ch = 0; ch < cfg_in_ch; ch++)
        begin
            for (int k = 0; k < 9; k++)
            begin
                idx = wt_index(r.filt, ch, k);
                if (idx < WEIGHT_DEPTH && !wt_set[idx])
                    send_load(ACT_WEIGHT, idx);
            end
            for (int row = 0; row < 4; row++)
                for (int col = 0; col < 4; col++)
                begin
                    idx = feat_index(ch, 2 * r.prow + row, 2 * r.pcol + col);
                    if (idx < FMAP_DEPTH && !feat_set[idx])
                        send_load(ACT_PIXEL, idx);
                end
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_pools.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] reg_sel, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (reg_sel)
            REG_MAP_WIDTH:    cfg_width = 32'(data[7:0]);
            REG_IN_CHANNELS:  cfg_in_ch = 32'(data[5:0]);
            REG_OUT_CHANNELS: cfg_out_ch = 32'(data[6:0]);
            default:          cfg_pix_major = data[0];
        endcase
        @(posedge clk);
    endtask

    task automatic run_random(int unsigned count);
        layer_req_t  r;
        int unsigned p;
        int unsigned sel;
        int unsigned start_count;
        longint      span;
        p = pool_size();
        start_count = sent_count;
        // operand fills count toward the budget
        while (sent_count - start_count < count)
        begin
            sel = $urandom_range(0, 99);
            r.addr = 15'($urandom);
            r.value = random_word();
            r.filt = 6'($urandom);
            r.prow = 6'($urandom);
            r.pcol = 6'($urandom);
            if (sel < 50)
            begin
                r.act = ACT_COMPUTE;
                r.filt = 6'($urandom_range(0, cfg_out_ch - 1));
                r.prow = 6'($urandom_range(0, p - 1));
                r.pcol = 6'($urandom_range(0, p - 1));
            end
            else if (sel < 58)
            begin
                // compute request with random fields, which may fall out of range
                r.act = ACT_COMPUTE;
            end
            else if (sel < 75)
            begin
                r.act = ACT_PIXEL;
                span = longint'(cfg_in_ch) * cfg_width * cfg_width;
                if (span > FMAP_DEPTH)
                    span = FMAP_DEPTH;
                if ($urandom_range(0, 3) != 0)
                    r.addr = 15'($urandom_range(0, 32'(span - 1)));
            end
            else if (sel < 90)
            begin
                r.act = ACT_WEIGHT;
                if ($urandom_range(0, 3) != 0)
                    r.addr = 15'($urandom_range(0, cfg_out_ch * cfg_in_ch * 9 - 1));
            end
            else
            begin
                r.act = ACT_BIAS;
                if ($urandom_range(0, 2) != 0)
                    r.addr = 15'($urandom_range(0, BIAS_DEPTH - 1));
            end
            if (r.act == ACT_COMPUTE)
                fill_operands(r);
            send_req(r);
        end
    endtask

    // directed vectors at the reset settings: map 128, one input channel, eight filters
    vector_row_t vectors [] = '{
        '{'{ACT_PIXEL,   15'h0000, 16'h7fff, 6'd0,  6'd0,  6'd0},  1'b0, '{0, 0, 0}},
        '{'{ACT_PIXEL,   15'h7fff, 16'h8000, 6'd63, 6'd63, 6'd63}, 1'b0, '{0, 0, 0}},
        '{'{ACT_PIXEL,   15'h5555, 16'h5555, 6'h15, 6'h2a, 6'h15}, 1'b0, '{0, 0, 0}},
        '{'{ACT_PIXEL,   15'h2aaa, 16'haaaa, 6'h2a, 6'h15, 6'h2a}, 1'b0, '{0, 0, 0}},
        '{'{ACT_WEIGHT,  15'h0000, 16'h8000, 6'd0,  6'd0,  6'd0},  1'b0, '{0, 0, 0}},
        '{'{ACT_WEIGHT,  15'h7fff, 16'h7fff, 6'd0,  6'd0,  6'd0},  1'b0, '{0, 0, 0}},
        '{'{ACT_BIAS,    15'd63,   16'h7fff, 6'd0,  6'd0,  6'd0},  1'b0, '{0, 0, 0}},
        '{'{ACT_BIAS,    15'd64,   16'h1234, 6'd0,  6'd0,  6'd0},  1'b0, '{0, 0, 0}},
        '{'{ACT_BIAS,    15'h7fff, 16'h8000, 6'd0,  6'd0,  6'd0},  1'b0, '{0, 0, 0}},
        '{'{ACT_BIAS,    15'd0,    16'hffff, 6'd0,  6'd0,  6'd0},  1'b0, '{0, 0, 0}},
        '{'{ACT_COMPUTE, 15'd0,    16'd0,    6'd8,  6'd0,  6'd0},  1'b1, '{0, 0, 1}},
        '{'{ACT_COMPUTE, 15'h7fff, 16'hffff, 6'd63, 6'd63, 6'd63}, 1'b1, '{0, 0, 1}},
        '{'{ACT_COMPUTE, 15'd0,    16'd0,    6'd0,  6'd63, 6'd0},  1'b1, '{0, 0, 1}},
        '{'{ACT_COMPUTE, 15'd0,    16'd0,    6'd0,  6'd0,  6'd63}, 1'b1, '{0, 0, 1}},
        '{'{ACT_COMPUTE, 15'd0,    16'd0,    6'd0,  6'd0,  6'd0},  1'b0, '{0, 0, 0}},
        '{'{ACT_COMPUTE, 15'd0,    16'd0,    6'd7,  6'd62, 6'd62}, 1'b0, '{0, 0, 0}},
        '{'{ACT_COMPUTE, 15'd0,    16'd0,    6'd3,  6'd31, 6'd40}, 1'b0, '{0, 0, 0}}
    };

    // settings per phase: map width, input channels, filters, pixel-major
    int unsigned phase_cfg [7][4] = '{
        '{4, 8, 4, 1},
        '{10, 3, 16, 0},
        '{128, 1, 1, 1},
        '{7, 2, 5, 1},
        '{13, 1, 64, 0},
        '{5, 4, 3, 0},
        '{20, 2, 8, 1}
    };

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_width = 128;
        cfg_in_ch = 1;
        cfg_out_ch = 8;
        cfg_pix_major = 1'b0;
        burst_left = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
        begin
            if (vectors[i].req.act == ACT_COMPUTE)
                fill_operands(vectors[i].req);
            send_req(vectors[i].req, vectors[i].typed, vectors[i].want);
        end
        run_random(60);

        foreach (phase_cfg[ph])
        begin
            drain_results();
            apb_write(REG_MAP_WIDTH, phase_cfg[ph][0]);
            apb_write(REG_IN_CHANNELS, phase_cfg[ph][1]);
            apb_write(REG_OUT_CHANNELS, phase_cfg[ph][2]);
            apb_write(REG_PIXEL_MAJOR, phase_cfg[ph][3]);
            run_random(RANDOM_ITEMS / 7);
        end

        drain_results();
        repeat (20) @(posedge clk);
        $display("Sent %0d transactions over 8 layer settings; %0d pooled results checked",
                 sent_count, result_count);
        $display("(%0d out-of-range requests, %0d saturated), %0d mismatches",
                 bad_count, saturated_count, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // result side: stall pattern rotates through four ready modes
    always @(posedge clk)
    begin
        pool_out_t exp_pool;
        if (rst_n)
        begin
            case ((cycle_count / 300) % 4)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 0);
                2: m_axis_tready <= (cycle_count % 5 == 0);
                default: m_axis_tready <= ($urandom_range(0, 15) == 0);
            endcase
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_pools.size() == 0)
                begin
                    $error("result with nothing pending: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    mismatch_count++;
                end
                else
                begin
                    exp_pool = pending_pools.pop_front();
                    result_count++;
                    if (exp_pool.bad)
                        bad_count++;
                    if (exp_pool.pooled == OUT_MAX)
                        saturated_count++;
                    if (m_axis_tdata[14:0] !== exp_pool.pooled)
                    begin
                        $error("pooled_value expected %0d actual %0d",
                               exp_pool.pooled, m_axis_tdata[14:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[29:15] !== exp_pool.index)
                    begin
                        $error("out_index expected %0d actual %0d",
                               exp_pool.index, m_axis_tdata[29:15]);
                        mismatch_count++;
                    end
                    if (m_axis_tuser !== exp_pool.bad)
                    begin
                        $error("bad_request expected %0d actual %0d",
                               exp_pool.bad, m_axis_tuser);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_pools.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
        cycle_count = 0;

endmodule
